// ===== rtl/core/utarp_pkg.sv =====
package utarp_pkg;

    // Packet layout
    localparam logic [4:0] HDR_BYTES     = 5'd20;
    localparam logic [2:0] ENTRY_BYTES   = 3'd6;
    localparam int         WORD_BYTES    = 4;
    localparam int         NUM_HDR_WORDS = 5;
    localparam logic [2:0] TID_WORD      = 3'd1;

    // Result buffer depth; at least two so that a byte with two results fits.
    localparam int FIFO_DEPTH = 4;

    // Result kinds
    localparam logic KIND_PEER    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Summary status codes
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SHORT    = 2'd1,
        STATUS_MISMATCH = 2'd2
    } t_status;

    typedef struct packed {
        logic                               kind;
        logic                               run_end;
        logic [31:0]                        peer_address;
        logic [15:0]                        peer_port;
        logic [NUM_HDR_WORDS-1:0][31:0]     hdr_words;
        t_status                            status;
    } t_result;

endpackage

// ===== rtl/core/udp_tracker_announce_response_parser.sv =====
// The results of an accepted byte are registered in the result buffer and leave it in order.
// Throughput: one byte per cycle while the result buffer has room; only a final byte that
// also completes a peer entry yields two results, which leave the result buffer in turn.
// Reset (i_rst_n low at a clock edge) clears the parser state, the result buffer
// and the expected transaction id; no clearing pass follows.
module udp_tracker_announce_response_parser #(
    parameter int P_FIFO_DEPTH = utarp_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // Configuration: expected transaction id
    input  logic                i_cfg_wr_en,
    input  logic signed [31:0]  i_cfg_wr_data,

    // Packet byte stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tlast,   // last_byte

    // Result stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [31:0] peer_address, [47:32] peer_port, [79:48] action_code,
    // [111:80] transaction_seen, [143:112] announce_interval,
    // [175:144] leecher_count, [207:176] seeder_count, [209:208] status,
    // [215:210] zero fill
    output logic [215:0]        m_axis_tdata,
    output logic                m_axis_tuser,   // result_kind
    output logic                m_axis_tlast    // run_end
);

    localparam int NW = utarp_pkg::NUM_HDR_WORDS;

    // Parser state. Header position counts header bytes and stops at 20;
    // after that, bytes only feed the peer entry shifter, whose counter
    // wraps every six bytes, so packets of any length are handled.
    logic [4:0]              r_hdr_pos;
    logic [31:0]             r_word_shift;
    logic [NW-1:0][31:0]     r_hdr_words;
    logic [47:0]             r_entry_shift;
    logic [2:0]              r_entry_pos;
    logic                    r_mismatch;
    logic [31:0]             r_expected_tid;

    logic [4:0]              n_hdr_pos;
    logic [31:0]             n_word_shift;
    logic [NW-1:0][31:0]     n_hdr_words;
    logic [47:0]             n_entry_shift;
    logic [2:0]              n_entry_pos;
    logic                    n_mismatch;

    logic                    in_accept;
    logic [2:0]              word_idx;
    logic [47:0]             entry_full;
    logic                    peer_hit;
    logic                    sum_hit;
    utarp_pkg::t_status      sum_status;
    utarp_pkg::t_result      peer_res;
    utarp_pkg::t_result      sum_res;
    utarp_pkg::t_result      push_a_data;
    logic                    fifo_room;
    utarp_pkg::t_result      out_res;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = fifo_room;

    // One byte of work: shift it into the header word or the peer entry,
    // store a finished header word, and check the transaction id when its
    // word completes (the eighth byte, against the register value then).
    always_comb begin
        n_hdr_pos     = r_hdr_pos;
        n_word_shift  = r_word_shift;
        n_hdr_words   = r_hdr_words;
        n_entry_shift = r_entry_shift;
        n_entry_pos   = r_entry_pos;
        n_mismatch    = r_mismatch;
        word_idx      = '0;
        entry_full    = {r_entry_shift[39:0], s_axis_tdata};
        peer_hit      = 1'b0;

        if (in_accept) begin
            if (r_hdr_pos < utarp_pkg::HDR_BYTES) begin
                n_word_shift = {r_word_shift[23:0], s_axis_tdata};
                n_hdr_pos    = r_hdr_pos + 5'd1;
                if (n_hdr_pos[1:0] == 2'b00) begin
                    word_idx = n_hdr_pos[4:2] - 3'd1;
                    for (int i = 0; i < NW; i++) begin
                        if (word_idx == 3'(i)) begin
                            n_hdr_words[i] = n_word_shift;
                        end
                    end
                    if (word_idx == utarp_pkg::TID_WORD && n_word_shift != r_expected_tid) begin
                        n_mismatch = 1'b1;
                    end
                    n_word_shift = '0;
                end
            end else begin
                n_entry_shift = entry_full;
                n_entry_pos   = r_entry_pos + 3'd1;
                if (n_entry_pos == utarp_pkg::ENTRY_BYTES) begin
                    // All-zero entries are padding and are dropped; after a
                    // transaction mismatch no peers are reported.
                    peer_hit      = (entry_full != '0) && !r_mismatch;
                    n_entry_shift = '0;
                    n_entry_pos   = '0;
                end
            end
        end

        sum_hit = in_accept && s_axis_tlast;

        // A short packet outranks a mismatch.
        if (n_hdr_pos < utarp_pkg::HDR_BYTES) begin
            sum_status = utarp_pkg::STATUS_SHORT;
        end else if (n_mismatch) begin
            sum_status = utarp_pkg::STATUS_MISMATCH;
        end else begin
            sum_status = utarp_pkg::STATUS_OK;
        end

        peer_res              = '0;
        peer_res.kind         = utarp_pkg::KIND_PEER;
        peer_res.run_end      = !sum_hit;
        peer_res.peer_address = entry_full[47:16];
        peer_res.peer_port    = entry_full[15:0];

        sum_res           = '0;
        sum_res.kind      = utarp_pkg::KIND_SUMMARY;
        sum_res.run_end   = 1'b1;
        sum_res.hdr_words = n_hdr_words;
        sum_res.status    = sum_status;

        // The packet ends here: everything but the register starts over.
        if (sum_hit) begin
            n_hdr_pos     = '0;
            n_word_shift  = '0;
            n_hdr_words   = '0;
            n_entry_shift = '0;
            n_entry_pos   = '0;
            n_mismatch    = 1'b0;
        end

        // A peer completed by the final byte goes out ahead of the summary.
        push_a_data = peer_hit ? peer_res : sum_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos      <= '0;
            r_word_shift   <= '0;
            r_hdr_words    <= '0;
            r_entry_shift  <= '0;
            r_entry_pos    <= '0;
            r_mismatch     <= 1'b0;
            r_expected_tid <= '0;
        end else begin
            r_hdr_pos     <= n_hdr_pos;
            r_word_shift  <= n_word_shift;
            r_hdr_words   <= n_hdr_words;
            r_entry_shift <= n_entry_shift;
            r_entry_pos   <= n_entry_pos;
            r_mismatch    <= n_mismatch;
            if (i_cfg_wr_en) begin
                r_expected_tid <= $unsigned(i_cfg_wr_data);
            end
        end
    end

    // The result buffer decouples the two sides: a new byte is taken while
    // results still wait, as long as there is room for the two results a
    // single byte can produce.
    utarp_res_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_res_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (peer_hit || sum_hit),
        .i_data_a (push_a_data),
        .i_push_b (peer_hit && sum_hit),
        .i_data_b (sum_res),
        .o_room   (fifo_room),
        .o_valid  (m_axis_tvalid),
        .o_data   (out_res),
        .i_pop    (m_axis_tready)
    );

    assign m_axis_tdata = {6'd0, out_res.status, out_res.hdr_words,
                           out_res.peer_port, out_res.peer_address};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.run_end;

    a_hdr_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= utarp_pkg::HDR_BYTES)
        else $error("header position beyond header length");

    a_entry_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entry_pos != '0) |-> (r_hdr_pos == utarp_pkg::HDR_BYTES)
                                && (r_entry_pos < utarp_pkg::ENTRY_BYTES))
        else $error("peer entry bytes counted outside the payload");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s_axis_tlast) |=> (r_hdr_pos == '0) && (r_entry_pos == '0)
                                        && !r_mismatch)
        else $error("parser state not cleared after packet end");

    a_mismatch_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mismatch) |-> ($past(r_hdr_pos) == 5'd7))
        else $error("mismatch raised away from the transaction id word");

endmodule

// ===== rtl/core/utarp_res_fifo.sv =====
module utarp_res_fifo #(
    parameter int P_DEPTH = utarp_pkg::FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_a,
    input  utarp_pkg::t_result  i_data_a,
    input  logic                i_push_b,
    input  utarp_pkg::t_result  i_data_b,
    output logic                o_room,
    output logic                o_valid,
    output utarp_pkg::t_result  o_data,
    input  logic                i_pop
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(P_DEPTH - 2);

    utarp_pkg::t_result r_mem [P_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic [PTR_W-1:0]   wr_ptr_1;
    logic [PTR_W-1:0]   wr_ptr_2;
    logic [PTR_W-1:0]   rd_ptr_1;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               pop_hit;

    assign wr_ptr_1 = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
    assign wr_ptr_2 = (wr_ptr_1 == LAST_IDX) ? '0 : wr_ptr_1 + 1'b1;
    assign rd_ptr_1 = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_room  = (r_count <= ROOM_MAX);
    assign pop_hit = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push_a && i_push_b) begin
            n_wr_ptr = wr_ptr_2;
        end else if (i_push_a) begin
            n_wr_ptr = wr_ptr_1;
        end
        n_rd_ptr = pop_hit ? rd_ptr_1 : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push_a) + CNT_W'(i_push_a && i_push_b)
                 - CNT_W'(pop_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < P_DEPTH; i++) begin
            if (i_push_a && (r_wr_ptr == PTR_W'(i))) begin
                r_mem[i] <= i_data_a;
            end else if (i_push_a && i_push_b && (wr_ptr_1 == PTR_W'(i))) begin
                r_mem[i] <= i_data_b;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(P_DEPTH))
        else $error("result buffer count exceeds depth");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_b |-> i_push_a)
        else $error("second result pushed without a first");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_a |-> o_room)
        else $error("result pushed without room");

endmodule

// ===== tb/udp_tracker_announce_response_parser_test.sv =====
`timescale 1ns / 1ps

module udp_tracker_announce_response_parser_test;

    // The run is stopped here whatever happens.
    localparam int RUN_LIMIT     = 400000;
    // Cycles left after the last expected result, so that a byte that causes no
    // result has surely passed through the block before a register write.
    localparam int SETTLE_CYCLES = 12;
    // Bytes sent in each random traffic phase.
    localparam int PHASE_BYTES   = 380;
    // Mismatch lines printed before further ones are only counted.
    localparam int PRINT_CAP     = 40;
    // Length of the receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES   = 80;

    // One result of the parser, as the testbench expects it.
    typedef struct packed {
        logic               kind;
        logic               run_end;
        logic [31:0]        address;
        logic [15:0]        port;
        logic [4:0][31:0]   words;
        utarp_pkg::t_status status;
    } t_announce_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [31:0]  i_cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;    // [7:0] data_byte
    logic         s_axis_tlast;    // last_byte
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [31:0] peer_address, [47:32] peer_port, [79:48] action_code,
    // [111:80] transaction_seen, [143:112] announce_interval,
    // [175:144] leecher_count, [207:176] seeder_count, [209:208] status,
    // [215:210] zero fill
    logic [215:0] m_axis_tdata;
    logic         m_axis_tuser;    // result_kind
    logic         m_axis_tlast;    // run_end

    udp_tracker_announce_response_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The clock runs with a period of 10 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser state as the testbench predicts it. The expected transaction id is
    // the testbench copy of the configuration register.
    logic [31:0]      tid_expected;
    logic [4:0]       hdr_count;
    logic [31:0]      hdr_accum;
    logic [4:0][31:0] hdr_words;
    logic [47:0]      peer_accum;
    logic [2:0]       peer_count;
    logic             tid_bad;

    // Results that the parser still owes, oldest first.
    t_announce_result pending_announce_results[$];

    // The packet being built by the stimulus, and traffic controls.
    logic [7:0] pkt_buf[$];
    int         bytes_sent     = 0;
    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         sink_hold_left = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    // Appends one byte to the packet under construction.
    function automatic void add_byte(input logic [7:0] value);
        pkt_buf.insert(pkt_buf.size(), value);
    endfunction

    // Queues one result behind those already owed.
    function automatic void expect_result(input t_announce_result res);
        pending_announce_results.insert(pending_announce_results.size(), res);
    endfunction

    // Everything but the configuration register returns to zero at packet end.
    function automatic void clear_packet_state();
        hdr_count  = '0;
        hdr_accum  = '0;
        hdr_words  = '0;
        peer_accum = '0;
        peer_count = '0;
        tid_bad    = 1'b0;
    endfunction

    // Works out the results that one accepted byte causes and queues them. The
    // first 20 bytes fill the five header words; the transaction id is checked
    // as soon as its word is complete. Later bytes form 6-byte peer entries.
    task automatic parse_announce_byte(input logic [7:0] data, input logic last);
        t_announce_result res;
        logic [2:0]       word_idx;
        res = '0;
        if (hdr_count < utarp_pkg::HDR_BYTES) begin
            hdr_accum = {hdr_accum[23:0], data};
            hdr_count = hdr_count + 5'd1;
            if (hdr_count[1:0] == 2'b00) begin
                word_idx = hdr_count[4:2] - 3'd1;
                hdr_words[word_idx] = hdr_accum;
                if (word_idx == utarp_pkg::TID_WORD && hdr_accum != tid_expected) begin
                    tid_bad = 1'b1;
                end
                hdr_accum = '0;
            end
        end else begin
            peer_accum = {peer_accum[39:0], data};
            peer_count = peer_count + 3'd1;
            if (peer_count == utarp_pkg::ENTRY_BYTES) begin
                // An all-zero entry is padding, and after a transaction
                // mismatch no peer is trusted.
                if (peer_accum != '0 && !tid_bad) begin
                    res.kind    = utarp_pkg::KIND_PEER;
                    res.address = peer_accum[47:16];
                    res.port    = peer_accum[15:0];
                    res.status  = utarp_pkg::STATUS_OK;
                    res.run_end = !last;
                    expect_result(res);
                end
                peer_accum = '0;
                peer_count = '0;
            end
        end
        if (last) begin
            // The summary comes after a peer that the final byte completed.
            // A short packet wins over a mismatch.
            res = '0;
            res.kind    = utarp_pkg::KIND_SUMMARY;
            res.run_end = 1'b1;
            res.words   = hdr_words;
            if (hdr_count < utarp_pkg::HDR_BYTES) begin
                res.status = utarp_pkg::STATUS_SHORT;
            end else if (tid_bad) begin
                res.status = utarp_pkg::STATUS_MISMATCH;
            end else begin
                res.status = utarp_pkg::STATUS_OK;
            end
            expect_result(res);
            clear_packet_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Every accepted result is compared with the oldest expectation. Sampling on
    // the falling edge sees the values that the next rising edge takes.
    always @(negedge i_clk) begin : result_check
        t_announce_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_announce_results.size() == 0) begin
                report_mismatch("result with nothing expected", {31'b0, m_axis_tuser}, '0);
            end else begin
                want = pending_announce_results.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    report_mismatch("result kind", {31'b0, m_axis_tuser}, {31'b0, want.kind});
                end
                if (m_axis_tlast !== want.run_end) begin
                    report_mismatch("run end", {31'b0, m_axis_tlast}, {31'b0, want.run_end});
                end
                if (m_axis_tdata[31:0] !== want.address) begin
                    report_mismatch("peer address", m_axis_tdata[31:0], want.address);
                end
                if (m_axis_tdata[47:32] !== want.port) begin
                    report_mismatch("peer port", {16'b0, m_axis_tdata[47:32]}, {16'b0, want.port});
                end
                for (int i = 0; i < utarp_pkg::NUM_HDR_WORDS; i++) begin
                    if (m_axis_tdata[48 + 32 * i +: 32] !== want.words[i]) begin
                        report_mismatch($sformatf("header word %0d", i),
                                        m_axis_tdata[48 + 32 * i +: 32], want.words[i]);
                    end
                end
                if (m_axis_tdata[209:208] !== want.status) begin
                    report_mismatch("status", {30'b0, m_axis_tdata[209:208]},
                                    {30'b0, want.status});
                end
                if (m_axis_tdata[215:210] !== 6'b0) begin
                    report_mismatch("zero fill", {26'b0, m_axis_tdata[215:210]}, '0);
                end
            end
        end
    end

    // The receiver stalls at random, or holds off completely while a hold-off
    // count set by a test is running down.
    always @(posedge i_clk) begin
        if (sink_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold_left = sink_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: a hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one byte, with random idle cycles ahead of it, and waits for the
    // handshake. It is entered and left just after a rising edge; valid stays
    // high after acceptance so that back-to-back bytes have no gap.
    task automatic send_byte(input logic [7:0] data, input logic last);
        logic taken;
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            taken = s_axis_tready;
            @(posedge i_clk);
        end while (!taken);
        parse_announce_byte(data, last);
    endtask

    // Sends the packet built in the buffer, flagging its final byte.
    task automatic send_packet();
        for (int i = 0; i < pkt_buf.size(); i++) begin
            send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
        end
        bytes_sent = bytes_sent + pkt_buf.size();
        pkt_buf.delete();
    endtask

    function automatic void add_word(input logic [31:0] word);
        for (int i = 3; i >= 0; i--) begin
            add_byte(word[8 * i +: 8]);
        end
    endfunction

    function automatic void add_entry(input logic [31:0] address, input logic [15:0] port);
        add_word(address);
        add_byte(port[15:8]);
        add_byte(port[7:0]);
    endfunction

    // A header word that often sits at the edge of the signed or unsigned range.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic void add_header(input logic [31:0] tid);
        // Action 1 is an announce reply; the parser passes any value through.
        add_word(($urandom_range(3) != 0) ? 32'd1 : rand_word());
        add_word(tid);
        add_word(rand_word());
        add_word(rand_word());
        add_word(rand_word());
    endfunction

    // Builds one random packet. Most are well formed with random content; the
    // rest are short packets and plain noise.
    task automatic build_random_packet();
        int          roll;
        int          entries;
        logic [31:0] tid;
        logic [31:0] address;
        logic [15:0] port;
        roll = $urandom_range(99);
        if (roll < 6) begin
            repeat ($urandom_range(1, 60)) add_byte(8'($urandom()));
        end else if (roll < 14) begin
            // Short packet; a wrong transaction id in it must not show.
            repeat ($urandom_range(1, 19)) add_byte(8'($urandom()));
        end else begin
            roll = $urandom_range(99);
            if (roll < 85) begin
                tid = tid_expected;
            end else if (roll < 93) begin
                tid = tid_expected ^ (32'd1 << $urandom_range(31));
            end else begin
                tid = $urandom();
            end
            add_header(tid);
            entries = ($urandom_range(19) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
            repeat (entries) begin
                address = $urandom();
                port    = 16'($urandom());
                case ($urandom_range(19))
                    0, 1:    add_entry('0, '0);
                    2:       add_entry('0, port);
                    3:       add_entry(address, '0);
                    default: add_entry(address, port);
                endcase
            end
            // An incomplete trailing entry produces nothing.
            if ($urandom_range(6) == 0) begin
                repeat ($urandom_range(1, 5)) add_byte(8'($urandom()));
            end
        end
    endtask

    // Stops offering and waits for every owed result, then lets the block settle.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_announce_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register is only written while the parser is idle.
    task automatic set_expected_tid(input logic [31:0] tid);
        wait_results_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= tid;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tid_expected = tid;
    endtask

    // A one-byte packet gets a short status and all-zero header words.
    task automatic test_short_packet();
        add_byte(8'hFF);
        send_packet();
    endtask

    // Header words at the extremes, and a peer entry of all ones completed by
    // the final byte, which must come out ahead of the summary.
    task automatic test_final_byte_entry();
        add_word(32'h8000_0000);
        add_word(tid_expected);
        add_word(32'h7FFF_FFFF);
        add_word(32'hFFFF_FFFF);
        add_word(32'h0000_0000);
        add_entry(32'hFFFF_FFFF, 16'hFFFF);
        send_packet();
    endtask

    // A zero entry is dropped, an entry with only a port is kept, and a partial
    // entry at the end is ignored.
    task automatic test_zero_and_partial_entries();
        add_word(32'd1);
        add_word(tid_expected);
        add_word(32'd1800);
        add_word(32'd3);
        add_word(32'd7);
        add_entry('0, '0);
        add_entry('0, 16'h0001);
        add_byte(8'hAB);
        add_byte(8'h00);
        send_packet();
    endtask

    // A wrong transaction id suppresses the peer and gives a mismatch status.
    task automatic test_tid_mismatch();
        add_word(32'd1);
        add_word(~tid_expected);
        add_word(32'd60);
        add_word(32'd0);
        add_word(32'd1);
        add_entry(32'h0A00_0001, 16'd6881);
        send_packet();
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input logic [31:0] tid);
        int start_count;
        set_expected_tid(tid);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        start_count    = bytes_sent;
        while (bytes_sent - start_count < PHASE_BYTES) begin
            build_random_packet();
            send_packet();
        end
    endtask

    // The receiver holds off while a long peer list streams in, so the result
    // buffer fills and the input stalls. Then the sender waits until every
    // result has come before it sends one more packet.
    task automatic test_backpressure();
        set_expected_tid($urandom());
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        @(negedge i_clk);
        sink_hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        add_header(tid_expected);
        repeat (16) add_entry($urandom() | 32'd1, 16'($urandom()));
        send_packet();
        wait_results_drained();
        add_header(tid_expected);
        repeat (4) add_entry($urandom() | 32'd1, 16'($urandom()));
        send_packet();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tid_expected  = '0;
        clear_packet_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The short packet runs with the register still at its reset value.
        test_short_packet();
        set_expected_tid(32'h8000_0000);
        test_final_byte_entry();
        test_zero_and_partial_entries();
        test_tid_mismatch();

        // Random traffic: no idling, then a mostly idle sender, then a mostly
        // stalling receiver, then light idling on both sides.
        test_random_traffic(0, 0, $urandom());
        test_random_traffic(81, 0, 32'h7FFF_FFFF);
        test_random_traffic(0, 81, 32'h0000_0000);
        test_random_traffic(17, 17, 32'hFFFF_FFFF);
        test_backpressure();

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
